FILE: src/bpam_pkg.sv
// bpam_pkg: shared types, widths and codes for the beacon period anomaly monitor
// no dependencies; imported by every module of the block
`default_nettype none

package bpam_pkg;

  // time stamps and fixed-point average
  localparam int TIME_BITS     = 48;
  localparam int AVG_FRAC_BITS = 3;
  localparam int AVG_BITS      = TIME_BITS + AVG_FRAC_BITS;
  // room for thirteen times the average
  localparam int CMP_BITS      = AVG_BITS + 4;

  localparam int SEQ_BITS = 32;
  localparam int REV_BITS = 16;
  localparam int OUT_BITS = 3;

  // sequence checks start at this protocol revision
  localparam logic [REV_BITS-1:0] SEQ_CHECK_REV  = 16'd10;
  // an advance above this looks like a step backwards
  localparam logic [SEQ_BITS-1:0] SEQ_BACK_LIMIT = 32'hFFFF_FEFF;
  localparam logic [SEQ_BITS-1:0] SEQ_ADV_NONE   = 32'd0;
  localparam logic [SEQ_BITS-1:0] SEQ_ADV_TWO    = 32'd2;
  localparam logic [SEQ_BITS-1:0] SEQ_ADV_THREE  = 32'd3;

  // configuration register indexes
  localparam int CFG_IDX_BITS  = 2;
  localparam int CFG_DATA_BITS = TIME_BITS;
  localparam logic [CFG_IDX_BITS-1:0] CFG_PROGRAM_START    = 2'd0;
  localparam logic [CFG_IDX_BITS-1:0] CFG_CIRCUIT_ATTACHED = 2'd1;

  // input kinds
  localparam logic KIND_BEACON = 1'b0;
  localparam logic KIND_FORGET = 1'b1;

  // outcome codes
  localparam logic [OUT_BITS-1:0] OUT_FIRST_BEACON = 3'd0;
  localparam logic [OUT_BITS-1:0] OUT_DISCARDED    = 3'd1;
  localparam logic [OUT_BITS-1:0] OUT_FIRST_PERIOD = 3'd2;
  localparam logic [OUT_BITS-1:0] OUT_LATE         = 3'd3;
  localparam logic [OUT_BITS-1:0] OUT_EARLY        = 3'd4;
  localparam logic [OUT_BITS-1:0] OUT_NORMAL       = 3'd5;
  localparam logic [OUT_BITS-1:0] OUT_FORGOTTEN    = 3'd6;

  typedef struct packed {
    logic                 kind;
    logic [TIME_BITS-1:0] arrival_time;
    logic [SEQ_BITS-1:0]  sequence_number;
    logic [REV_BITS-1:0]  protocol_revision;
  } item_t;

  typedef struct packed {
    logic [TIME_BITS-1:0] last_arrival;
    logic                 stamp_valid;
    logic [AVG_BITS-1:0]  average_fixed;
    logic                 average_known;
    logic [SEQ_BITS-1:0]  last_sequence;
  } state_t;

  typedef struct packed {
    logic [OUT_BITS-1:0]  outcome;
    logic                 net_change;
    logic                 anomaly_notify;
    logic                 arrival_notify;
    logic [TIME_BITS-1:0] average_period;
    logic                 average_valid;
  } result_t;

endpackage

`default_nettype wire

FILE: src/bpam_state_regs.sv
// bpam_state_regs: per-server tracking state (last stamp, sequence, average)
// depends on bpam_pkg
`default_nettype none

module bpam_state_regs
  import bpam_pkg::*;
(
  input  wire logic   clk,
  input  wire logic   rst,
  input  wire logic   update,
  input  wire state_t state_next,
  output state_t      state
);

  // load the next state whenever an item finishes
  always_ff @(posedge clk) begin
    if (rst) begin
      state <= '0;
    end else if (update) begin
      state <= state_next;
    end
  end

endmodule

`default_nettype wire

FILE: src/bpam_classify.sv
// bpam_classify: one-pass evaluation of a beacon or forget transaction
// depends on bpam_pkg
`default_nettype none

module bpam_classify
  import bpam_pkg::*;
(
  input  wire item_t                  item,
  input  wire state_t                 state,
  input  wire logic [TIME_BITS-1:0]   program_start_time,
  input  wire logic                   circuit_attached,
  output state_t                      state_next,
  output result_t                     result
);

  logic                 seq_check;
  logic [SEQ_BITS-1:0]  seq_diff;
  logic [SEQ_BITS-1:0]  seq_adv;
  logic                 discard;
  logic [TIME_BITS-1:0] period;
  logic [TIME_BITS-1:0] running;
  logic [CMP_BITS-1:0]  per_fix;
  logic [CMP_BITS-1:0]  per_x4;
  logic [CMP_BITS-1:0]  per_x5;
  logic [CMP_BITS-1:0]  avg;
  logic [CMP_BITS-1:0]  avg_x4;
  logic [CMP_BITS-1:0]  avg_x5;
  logic [CMP_BITS-1:0]  avg_x7;
  logic [CMP_BITS-1:0]  avg_x13;
  logic [CMP_BITS-1:0]  avg_sum;
  logic                 is_late;
  logic                 is_very_late;
  logic                 is_early;

  // sequence advance with the wrap formula
  assign seq_check = item.protocol_revision >= SEQ_CHECK_REV;
  assign seq_diff  = item.sequence_number - state.last_sequence;
  assign seq_adv   = (item.sequence_number >= state.last_sequence) ? seq_diff
                                                                   : seq_diff - 1'b1;
  assign discard   = seq_check && ((seq_adv == SEQ_ADV_NONE) || (seq_adv == SEQ_ADV_TWO) ||
                                   (seq_adv == SEQ_ADV_THREE) || (seq_adv > SEQ_BACK_LIMIT));

  // period and running time, modulo the time width
  assign period  = item.arrival_time - state.last_arrival;
  assign running = state.last_arrival - program_start_time;

  // constant-factor multiples as shift-adds
  assign per_fix = CMP_BITS'(period) << AVG_FRAC_BITS;
  assign per_x4  = per_fix << 2;
  assign per_x5  = per_x4 + per_fix;
  assign avg     = CMP_BITS'(state.average_fixed);
  assign avg_x4  = avg << 2;
  assign avg_x5  = avg_x4 + avg;
  assign avg_x7  = (avg << 3) - avg;
  assign avg_x13 = (avg << 3) + avg_x5;

  // period >= 1.25 avg, >= 3.25 avg, <= 0.8 avg
  assign is_late      = per_x4 >= avg_x5;
  assign is_very_late = per_x4 >= avg_x13;
  assign is_early     = per_x5 <= avg_x4;

  // running average: period/8 + 7/8 avg, truncated
  assign avg_sum = per_fix + avg_x7;

  always_comb begin
    state_next            = state;
    result                = '0;
    result.outcome        = OUT_FIRST_BEACON;

    if (item.kind == KIND_FORGET) begin
      state_next.stamp_valid   = 1'b0;
      state_next.average_known = 1'b0;
      state_next.average_fixed = '0;
      result.outcome           = OUT_FORGOTTEN;
    end else if (!state.stamp_valid) begin
      if (seq_check) begin
        state_next.last_sequence = item.sequence_number;
      end
      state_next.last_arrival = item.arrival_time;
      state_next.stamp_valid  = 1'b1;
      result.anomaly_notify   = circuit_attached;
      result.outcome          = OUT_FIRST_BEACON;
    end else begin
      if (seq_check) begin
        state_next.last_sequence = item.sequence_number;
      end
      if (discard) begin
        result.outcome = OUT_DISCARDED;
      end else begin
        state_next.last_arrival = item.arrival_time;
        if (!state.average_known) begin
          // second beacon seeds the average
          state_next.average_fixed = AVG_BITS'(per_fix);
          state_next.average_known = 1'b1;
          result.anomaly_notify    = circuit_attached;
          result.net_change        = period <= running;
          result.outcome           = OUT_FIRST_PERIOD;
        end else begin
          state_next.average_fixed = AVG_BITS'(avg_sum >> AVG_FRAC_BITS);
          if (is_late) begin
            result.anomaly_notify = circuit_attached;
            result.net_change     = is_very_late;
            result.outcome        = OUT_LATE;
          end else if (is_early) begin
            result.anomaly_notify = circuit_attached;
            result.net_change     = 1'b1;
            result.outcome        = OUT_EARLY;
          end else begin
            result.arrival_notify = circuit_attached;
            result.outcome        = OUT_NORMAL;
          end
        end
      end
    end

    // estimate as it stands after this transaction
    result.average_valid  = state_next.average_known;
    result.average_period = state_next.average_known ?
                            state_next.average_fixed[AVG_BITS-1:AVG_FRAC_BITS] : '0;
  end

endmodule

`default_nettype wire

FILE: src/beacon_period_anomaly_monitor.sv
// beacon_period_anomaly_monitor: tracks beacon period of one server, flags anomalies
// pipeline: a transaction accepted into the input register is classified and moves
// into the result register when out_valid is low or out_ready is high
// throughput: one transaction per cycle unless stalled; both full, in_ready follows out_ready
// reset: synchronous rst clears all tracking state, both config registers and the pipeline
// depends on bpam_pkg, bpam_classify, bpam_state_regs
`default_nettype none

module beacon_period_anomaly_monitor
  import bpam_pkg::*;
(
  input  wire logic                     clk,
  input  wire logic                     rst,
  // configuration writes
  input  wire logic                     cfg_valid,
  output logic                          cfg_ready,
  input  wire logic [CFG_IDX_BITS-1:0]  cfg_index,
  input  wire logic [CFG_DATA_BITS-1:0] cfg_data,
  // input transactions
  input  wire logic                     in_valid,
  output logic                          in_ready,
  input  wire logic                     kind,
  input  wire logic [TIME_BITS-1:0]     arrival_time,
  input  wire logic [SEQ_BITS-1:0]      sequence_number,
  input  wire logic [REV_BITS-1:0]      protocol_revision,
  // result transactions
  output logic                          out_valid,
  input  wire logic                     out_ready,
  output logic [OUT_BITS-1:0]           outcome,
  output logic                          net_change,
  output logic                          anomaly_notify,
  output logic                          arrival_notify,
  output logic [TIME_BITS-1:0]          average_period,
  output logic                          average_valid
);

  logic [TIME_BITS-1:0] program_start_time;
  logic                 circuit_attached;
  logic                 in_full;
  item_t                in_item;
  logic                 advance;
  state_t               state;
  state_t               state_next;
  result_t              result;
  result_t              out_res;

  // configuration registers
  assign cfg_ready = 1'b1;

  always_ff @(posedge clk) begin
    if (rst) begin
      program_start_time <= '0;
      circuit_attached   <= 1'b0;
    end else if (cfg_valid && cfg_ready) begin
      unique case (cfg_index)
        CFG_PROGRAM_START:    program_start_time <= cfg_data;
        CFG_CIRCUIT_ATTACHED: circuit_attached   <= cfg_data[0];
        default: ;
      endcase
    end
  end

  // pipeline handshake
  assign advance  = in_full && (!out_valid || out_ready);
  assign in_ready = !in_full || advance;

  // input register
  always_ff @(posedge clk) begin
    if (rst) begin
      in_full <= 1'b0;
    end else if (in_valid && in_ready) begin
      in_full <= 1'b1;
    end else if (advance) begin
      in_full <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (in_valid && in_ready) begin
      in_item.kind              <= kind;
      in_item.arrival_time      <= arrival_time;
      in_item.sequence_number   <= sequence_number;
      in_item.protocol_revision <= protocol_revision;
    end
  end

  bpam_classify u_classify (
    .item               (in_item),
    .state              (state),
    .program_start_time (program_start_time),
    .circuit_attached   (circuit_attached),
    .state_next         (state_next),
    .result             (result)
  );

  bpam_state_regs u_state (
    .clk        (clk),
    .rst        (rst),
    .update     (advance),
    .state_next (state_next),
    .state      (state)
  );

  // result register
  always_ff @(posedge clk) begin
    if (rst) begin
      out_valid <= 1'b0;
    end else if (advance) begin
      out_valid <= 1'b1;
    end else if (out_ready) begin
      out_valid <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (advance) begin
      out_res <= result;
    end
  end

  assign outcome        = out_res.outcome;
  assign net_change     = out_res.net_change;
  assign anomaly_notify = out_res.anomaly_notify;
  assign arrival_notify = out_res.arrival_notify;
  assign average_period = out_res.average_period;
  assign average_valid  = out_res.average_valid;

endmodule

`default_nettype wire

FILE: src/bpam_checker.sv
// bpam_checker: port-level assertions for the beacon period anomaly monitor
// depends on bpam_pkg; bound to beacon_period_anomaly_monitor below
`default_nettype none

module bpam_checker
  import bpam_pkg::*;
(
  input wire logic                 clk,
  input wire logic                 rst,
  input wire logic                 out_valid,
  input wire logic                 out_ready,
  input wire logic [OUT_BITS-1:0]  outcome,
  input wire logic                 net_change,
  input wire logic                 anomaly_notify,
  input wire logic                 arrival_notify,
  input wire logic [TIME_BITS-1:0] average_period,
  input wire logic                 average_valid
);

  // no result right after reset
  a_idle_after_reset: assert property (@(posedge clk) !rst && $past(rst) |-> !out_valid)
    else $error("result valid right after reset");

  // a forget transaction leaves no estimate and no flags
  a_forget_clears: assert property (@(posedge clk) disable iff (rst)
    out_valid && (outcome == OUT_FORGOTTEN) |->
      !average_valid && !net_change && !anomaly_notify && !arrival_notify &&
      (average_period == '0))
    else $error("forget transaction left estimate or flags");

  // arrival notices only for normal beacons
  a_arrival_normal: assert property (@(posedge clk) disable iff (rst)
    out_valid && arrival_notify |-> (outcome == OUT_NORMAL) && !anomaly_notify)
    else $error("arrival notice on a non-normal beacon");

  // network change only where a period was measured
  a_net_change_kind: assert property (@(posedge clk) disable iff (rst)
    out_valid && net_change |->
      (outcome == OUT_FIRST_PERIOD) || (outcome == OUT_LATE) || (outcome == OUT_EARLY))
    else $error("network change without a measured period");

  // a stalled result holds
  a_result_holds: assert property (@(posedge clk) disable iff (rst)
    out_valid && !out_ready |=> out_valid && $stable(outcome) && $stable(average_period))
    else $error("stalled result changed");

endmodule

bind beacon_period_anomaly_monitor bpam_checker u_bpam_checker (
  .clk            (clk),
  .rst            (rst),
  .out_valid      (out_valid),
  .out_ready      (out_ready),
  .outcome        (outcome),
  .net_change     (net_change),
  .anomaly_notify (anomaly_notify),
  .arrival_notify (arrival_notify),
  .average_period (average_period),
  .average_valid  (average_valid)
);

`default_nettype wire
